/* rtl/core/slt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted list table package
// Shared types and constants for the sorted table and its cell row.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 8;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef enum logic {
      SLT_IDLE,
      SLT_UPDATE
   } state_type;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count_after;
   } rsp_type;

   // Broadcast to every cell in the update cycle.
   typedef struct packed {
      logic                      shift_up;
      logic                      shift_down;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

/* rtl/core/slt_cell.sv */
// ----------------------------------------------------------------------------
// Sorted list table cell
// Holds one table slot, compares it against the broadcast key and shifts
// toward either neighbor when the table opens or closes a gap.
// ----------------------------------------------------------------------------
module slt_cell import slt_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = 8
) (
   input  logic                      clock,
   input  logic                      cmp_en,
   input  logic signed [VALUE_W-1:0] key,
   input  logic [CNT_W-1:0]          count,
   input  cell_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic                      left_open,
   input  logic signed [VALUE_W-1:0] right_entry,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      le,
   output logic                      lt,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      le_ff, lt_ff, eq_ff;
   logic                      le_in, lt_in, eq_in;
   logic                      slot_valid;

   assign slot_valid = CNT_W'(INDEX) < count;

   always_comb begin
      le_in = le_ff;
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (cmp_en) begin
         le_in = slot_valid && (entry_ff <= key);
         lt_in = slot_valid && (entry_ff <  key);
         eq_in = slot_valid && (entry_ff == key);
      end
   end

   // On insert, every slot past the insert point takes its left neighbor;
   // the slot at the insert point itself takes the new value.
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.shift_up) begin
         priority if (left_open) begin
            entry_in = left_entry;
         end else if (!le_ff) begin
            entry_in = ctrl.value;
         end else begin
            entry_in = entry_ff;
         end
      end else if (ctrl.shift_down && !lt_ff) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      le_ff    <= le_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign le    = le_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

/* rtl/core/sorted_list_table.sv */
// Requests are taken only while idle, one command at a time; every cell compares in the
// accept cycle, and the whole row shifts and the result beat is registered in the update
// state, which waits while a held result beat is stalled.
// Reset clears the entry count, the control state and the result valid flag;
// table entries are not cleared and are only read below the entry count.
// ----------------------------------------------------------------------------
// Sorted list table
// Ascending table of signed words with insert, search and remove commands,
// built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module sorted_list_table import slt_pkg::*; #(
   parameter int CAPACITY = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       cmd_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic req_accept, upd_fire;
   cell_ctrl_type ctrl;

   logic signed [VALUE_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0] le_vec, lt_vec, eq_vec;
   logic [CAPACITY-1:0] ins_edge, find_edge;
   logic [IDX_W-1:0]    ins_pos, find_pos;
   logic                hit, full;

   // Cell row.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry, right_entry;
      logic                      left_open;
      if (i == 0) begin : g_first
         assign left_entry = entry_vec[0];
         assign left_open  = 1'b0;
      end else begin : g_mid
         assign left_entry = entry_vec[i-1];
         assign left_open  = !le_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_vec[i];
      end else begin : g_inner
         assign right_entry = entry_vec[i+1];
      end
      slt_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmp_en      (req_accept),
         .key         (req.value),
         .count       (count_ff),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_open   (left_open),
         .right_entry (right_entry),
         .entry       (entry_vec[i]),
         .le          (le_vec[i]),
         .lt          (lt_vec[i]),
         .eq          (eq_vec[i])
      );
   end

   // The flags form a prefix, so each edge vector is one-hot at most.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            ins_edge[i]  = !le_vec[i];
            find_edge[i] = !lt_vec[i];
         end else begin
            ins_edge[i]  = !le_vec[i] && le_vec[i-1];
            find_edge[i] = !lt_vec[i] && lt_vec[i-1];
         end
      end
   end

   always_comb begin
      ins_pos  = '0;
      find_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ins_edge[i])  ins_pos  = ins_pos  | IDX_W'(i);
         if (find_edge[i]) find_pos = find_pos | IDX_W'(i);
      end
   end

   assign hit  = |(find_edge & eq_vec);
   assign full = (count_ff == CNT_W'(CAPACITY));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SLT_IDLE:   if (req_valid) state_in = SLT_UPDATE;
         SLT_UPDATE: if (!rsp_valid_ff || !rsp_stall) state_in = SLT_IDLE;
         default:    state_in = SLT_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      upd_fire  = 1'b0;
      unique case (state_ff)
         SLT_IDLE:   req_stall = 1'b0;
         SLT_UPDATE: upd_fire  = !rsp_valid_ff || !rsp_stall;
         default:    req_stall = 1'b1;
      endcase
   end

   assign req_accept = req_valid && !req_stall;

   // Command decode and result build.
   always_comb begin
      logic [IDX_W+POS_W-1:0]   pos_wide;
      logic [CNT_W+COUNT_W-1:0] cnt_wide;
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;
      ctrl.value      = value_ff;
      count_in        = count_ff;
      rsp_in.status   = ST_OK;
      pos_wide        = '0;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               pos_wide      = {{POS_W{1'b0}}, ins_pos};
               ctrl.shift_up = upd_fire;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         CMD_SEARCH, CMD_REMOVE: begin
            if (!hit) begin
               rsp_in.status = ST_MISSING;
            end else begin
               pos_wide = {{POS_W{1'b0}}, find_pos};
               if (cmd_ff == CMD_REMOVE) begin
                  ctrl.shift_down = upd_fire;
                  count_in        = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
      cnt_wide           = {{COUNT_W{1'b0}}, count_in};
      rsp_in.position    = pos_wide[POS_W-1:0];
      rsp_in.count_after = cnt_wide[COUNT_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SLT_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_fire) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req.command;
         value_ff <= req.value;
      end
      if (upd_fire) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/core/slt_checker.sv */
// ----------------------------------------------------------------------------
// Sorted list table checker
// Port-level properties of the sorted table, bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker import slt_pkg::*; #(
   parameter int CAPACITY = 128
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY % 256);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result beat changed");

   // The table works on one command at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a command is in flight");

   // Failed commands report position zero.
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != ST_OK) |-> rsp.position == '0)
      else $error("nonzero position on a failed command");

   // A refused insert only happens on a full table.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == ST_FULL) |-> rsp.count_after == FULL_COUNT)
      else $error("insert refused below capacity");

endmodule

bind sorted_list_table slt_checker #(
   .CAPACITY (CAPACITY)
) u_slt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

/* bench/slt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list table scoreboard
// Watches both channels of the sorted table. Each accepted request beat is
// applied to a private copy of the table, and the response that it should
// produce is queued. Each accepted response beat is compared field by field
// with the oldest queued response.
// ----------------------------------------------------------------------------
module slt_scoreboard import slt_pkg::*; #(
   parameter int CAPACITY = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp,
   output int      mismatch_count,
   output int      outstanding
);

   // Ascending copy of the table contents.
   logic signed [VALUE_W-1:0] held_values[$];
   rsp_type                   awaited_rsp[$];
   int                        error_total = 0;

   function automatic rsp_type apply_command(req_type beat);
      rsp_type                   result;
      int                        slot;
      logic signed [VALUE_W-1:0] key;
      key                = $signed(beat.value);
      result.status      = ST_OK;
      result.position    = '0;
      case (beat.command)
         CMD_INSERT: begin
            if (held_values.size() >= CAPACITY) begin
               result.status = ST_FULL;
            end else begin
               // Equal entries stay ahead of the new one.
               slot = 0;
               while (slot < held_values.size() && held_values[slot] <= key) slot++;
               held_values.insert(slot, key);
               result.position = POS_W'(slot);
            end
         end
         CMD_SEARCH, CMD_REMOVE: begin
            slot = -1;
            for (int i = 0; i < held_values.size(); i++) begin
               if (slot < 0 && held_values[i] == key) slot = i;
            end
            if (slot < 0) begin
               result.status = ST_MISSING;
            end else begin
               result.position = POS_W'(slot);
               if (beat.command == CMD_REMOVE) held_values.delete(slot);
            end
         end
         default: ;
      endcase
      result.count_after = COUNT_W'(held_values.size());
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) awaited_rsp.push_back(apply_command(req));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected response status=%0d position=%0d count=%0d",
                        $time, rsp.status, rsp.position, rsp.count_after);
               error_total++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp.status !== want.status || rsp.position !== want.position ||
                   rsp.count_after !== want.count_after) begin
                  $display("%0t: status/position/count expected %0d/%0d/%0d got %0d/%0d/%0d",
                           $time, want.status, want.position, want.count_after,
                           rsp.status, rsp.position, rsp.count_after);
                  error_total++;
               end
            end
         end
      end
      mismatch_count <= error_total;
      outstanding    <= awaited_rsp.size();
   end

endmodule

/* bench/tb_sorted_list_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list table testbench
// Drives insert, search and remove commands into the sorted table with random
// gaps and response stalls, and reports the verdict of the attached checker.
// A directed opening covers empty and duplicate cases and the word extremes;
// the random part cycles through fill, mixed and drain phases.
// ----------------------------------------------------------------------------
module tb_sorted_list_table;
   import slt_pkg::*;

   localparam int         CAPACITY     = 128;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         PHASE_BEATS  = 275;
   localparam int         PHASE_COUNT  = 6;
   localparam int         POOL_SIZE    = 20;
   localparam int         STALL_LIMIT  = 4000;
   localparam int         DRAIN_CYCLES = 12;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp;

   int mismatch_count;
   int outstanding;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   logic signed [VALUE_W-1:0] key_pool[POOL_SIZE];

   sorted_list_table #(.CAPACITY(CAPACITY)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   slt_scoreboard #(.CAPACITY(CAPACITY)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req            (req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp            (rsp),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 16);
   end

   // Ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Holds valid high from one beat to the next unless a gap is drawn.
   task automatic issue_command(logic [1:0] command, logic signed [VALUE_W-1:0] value);
      while (!quiet && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= '{command: command, value: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(15) == 0) return $urandom;
      return key_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   task automatic refill_pool();
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = 0;
      key_pool[3] = -1;
      key_pool[4] = 1;
      for (int i = 5; i < POOL_SIZE; i++) begin
         if (i % 2 == 0) key_pool[i] = $urandom;
         else key_pool[i] = $signed($urandom_range(40)) - 20;
      end
   endtask

   initial begin
      int         draw;
      logic [1:0] command;
      reset     = 1'b1;
      req_valid = 1'b0;
      req       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, unused code, extremes and duplicates.
      issue_command(CMD_SEARCH, 5);
      issue_command(CMD_REMOVE, 5);
      issue_command(CMD_UNUSED, 5);
      issue_command(CMD_INSERT, 0);
      issue_command(CMD_INSERT, 32'sh7fff_ffff);
      issue_command(CMD_INSERT, 32'sh8000_0000);
      issue_command(CMD_INSERT, -1);
      issue_command(CMD_INSERT, 0);
      issue_command(CMD_INSERT, 0);
      issue_command(CMD_SEARCH, 0);
      issue_command(CMD_SEARCH, 32'sh7fff_ffff);
      issue_command(CMD_SEARCH, 32'sh8000_0000);
      issue_command(CMD_SEARCH, 7);
      issue_command(CMD_REMOVE, 0);
      issue_command(CMD_REMOVE, 32'sh8000_0000);
      issue_command(CMD_REMOVE, 7);
      issue_command(CMD_UNUSED, 32'sh7fff_ffff);
      issue_command(CMD_INSERT, 1);
      issue_command(CMD_SEARCH, -1);
      issue_command(CMD_REMOVE, 32'sh7fff_ffff);
      issue_command(CMD_REMOVE, -1);
      issue_command(CMD_SEARCH, 0);

      // Each round of fill, mixed and drain phases shares one key pool so that searches and
      // removes mostly hit, and the fill phase runs the table into refusals.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase % 3 == 0) refill_pool();
         quiet = (phase == 4);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            draw = $urandom_range(99);
            if (draw < 3) begin
               command = CMD_UNUSED;
            end else begin
               case (phase % 3)
                  0:       command = (draw < 78) ? CMD_INSERT :
                                     (draw < 88) ? CMD_SEARCH : CMD_REMOVE;
                  1:       command = (draw < 43) ? CMD_INSERT :
                                     (draw < 73) ? CMD_SEARCH : CMD_REMOVE;
                  default: command = (draw < 18) ? CMD_INSERT :
                                     (draw < 28) ? CMD_SEARCH : CMD_REMOVE;
               endcase
            end
            issue_command(command, pick_value());
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sorted_list_table.f */
rtl/core/slt_pkg.sv
rtl/core/slt_cell.sv
rtl/core/sorted_list_table.sv
rtl/core/slt_checker.sv
bench/slt_checker.sv
bench/tb_sorted_list_table.sv
